// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the branch-bit queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/bbpq_pkg.sv =====
// Package: types and constants of the branch-bit packet queue.
`timescale 1ns / 1ps
package bbpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int WORD_W      = 64;
    localparam int POS_W       = 6;
    localparam int TOTAL_W     = 10;

    localparam logic [POS_W-1:0]   SHORT_OFFSET = 6'd1;
    localparam logic [POS_W-1:0]   LONG_OFFSET  = 6'd16;
    localparam logic [TOTAL_W:0]   TOTAL_LIMIT  = 11'd1023;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_TAKE   = 1'b1;

    typedef enum logic [2:0] {
        OUT_NOT_TAKEN = 3'd0,
        OUT_TAKEN     = 3'd1,
        OUT_EMPTY     = 3'd2,
        OUT_APPENDED  = 3'd3,
        OUT_IGNORED   = 3'd4,
        OUT_DROPPED   = 3'd5
    } t_outcome;

    typedef struct packed {
        logic              kind;
        logic              is_long;
        logic [WORD_W-1:0] packet;
    } t_item;

    typedef struct packed {
        t_outcome           outcome;
        logic [TOTAL_W-1:0] pending_bits;
    } t_result;

endpackage

// ===== rtl/core/bbpq_stop_enc.sv =====
// Priority encoder: position of the highest set bit of a packet word.
`timescale 1ns / 1ps
module bbpq_stop_enc (
    input  logic [bbpq_pkg::WORD_W-1:0] i_word,
    output logic                        o_found,
    output logic [bbpq_pkg::POS_W-1:0]  o_pos
);

    always_comb begin
        o_found = 1'b0;
        o_pos   = '0;
        for (int i = 0; i < bbpq_pkg::WORD_W; i++) begin
            if (i_word[i]) begin
                o_found = 1'b1;
                o_pos   = bbpq_pkg::POS_W'(i);
            end
        end
    end

endmodule

// ===== rtl/core/bbpq_queue.sv =====
// Packet queue state and the per-item append/take step.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bbpq_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  bbpq_pkg::t_item   i_item,
    output bbpq_pkg::t_result o_result
);

    logic [bbpq_pkg::WORD_W-1:0]  r_word [bbpq_pkg::QUEUE_DEPTH];
    logic [bbpq_pkg::POS_W-1:0]   r_len  [bbpq_pkg::QUEUE_DEPTH];
    logic                         r_long [bbpq_pkg::QUEUE_DEPTH];

    logic [bbpq_pkg::SLOT_W-1:0]  r_head, n_head;
    logic [bbpq_pkg::SLOT_W-1:0]  r_tail, n_tail;
    logic [bbpq_pkg::COUNT_W-1:0] r_count, n_count;
    logic [bbpq_pkg::POS_W-1:0]   r_consumed, n_consumed;
    logic [bbpq_pkg::TOTAL_W-1:0] r_total, n_total;

    logic                         stop_found;
    logic [bbpq_pkg::POS_W-1:0]   stop_pos;
    logic [bbpq_pkg::POS_W-1:0]   app_offset;
    logic [bbpq_pkg::POS_W-1:0]   app_len;
    logic [bbpq_pkg::TOTAL_W:0]   app_sum;
    logic                         wr_en;
    logic [bbpq_pkg::POS_W-1:0]   head_len;
    logic [bbpq_pkg::POS_W-1:0]   head_offset;
    logic [bbpq_pkg::POS_W-1:0]   head_pos;
    logic                         head_bit;
    bbpq_pkg::t_outcome           outcome;

    bbpq_stop_enc u_stop_enc (
        .i_word  (i_item.packet),
        .o_found (stop_found),
        .o_pos   (stop_pos)
    );

    assign app_offset = i_item.is_long ? bbpq_pkg::LONG_OFFSET : bbpq_pkg::SHORT_OFFSET;
    assign app_len    = stop_pos - app_offset;
    assign app_sum    = {1'b0, r_total} + (bbpq_pkg::TOTAL_W + 1)'(app_len);

    // Head entry: next bit sits just below the stop bit, walking down.
    assign head_len    = r_len[r_head];
    assign head_offset = r_long[r_head] ? bbpq_pkg::LONG_OFFSET : bbpq_pkg::SHORT_OFFSET;
    assign head_pos    = head_len + head_offset - bbpq_pkg::POS_W'(1) - r_consumed;
    assign head_bit    = r_word[r_head][head_pos];

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_consumed = r_consumed;
        n_total    = r_total;
        wr_en      = 1'b0;
        outcome    = bbpq_pkg::OUT_EMPTY;
        if (i_item.kind == bbpq_pkg::KIND_APPEND) begin
            if (!stop_found || stop_pos <= app_offset) begin
                outcome = bbpq_pkg::OUT_IGNORED;
            end else if (r_count >= bbpq_pkg::COUNT_W'(bbpq_pkg::QUEUE_DEPTH)
                         || app_sum > bbpq_pkg::TOTAL_LIMIT) begin
                outcome = bbpq_pkg::OUT_DROPPED;
            end else begin
                outcome = bbpq_pkg::OUT_APPENDED;
                wr_en   = 1'b1;
                n_tail  = (r_tail == bbpq_pkg::SLOT_W'(bbpq_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_tail + bbpq_pkg::SLOT_W'(1);
                n_count = r_count + bbpq_pkg::COUNT_W'(1);
                n_total = app_sum[bbpq_pkg::TOTAL_W-1:0];
            end
        end else if (r_count != '0) begin
            outcome    = head_bit ? bbpq_pkg::OUT_TAKEN : bbpq_pkg::OUT_NOT_TAKEN;
            n_total    = (r_total != '0) ? r_total - bbpq_pkg::TOTAL_W'(1) : r_total;
            n_consumed = r_consumed + bbpq_pkg::POS_W'(1);
            if (n_consumed >= head_len) begin
                n_consumed = '0;
                n_head     = (r_head == bbpq_pkg::SLOT_W'(bbpq_pkg::QUEUE_DEPTH - 1))
                             ? '0 : r_head + bbpq_pkg::SLOT_W'(1);
                n_count    = r_count - bbpq_pkg::COUNT_W'(1);
            end
        end
    end

    assign o_result.outcome      = outcome;
    assign o_result.pending_bits = n_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_consumed <= '0;
            r_total    <= '0;
        end else if (i_step) begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_consumed <= n_consumed;
            r_total    <= n_total;
        end
    end

    // Entry storage: no reset, written only at the tail.
    always_ff @(posedge i_clk) begin
        if (i_step && wr_en) begin
            r_word[r_tail] <= i_item.packet;
            r_len[r_tail]  <= app_len;
            r_long[r_tail] <= i_item.is_long;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= bbpq_pkg::COUNT_W'(bbpq_pkg::QUEUE_DEPTH))
    `ASSERT_IMPLIES(a_empty_idle, i_clk, i_rst_n, r_count == '0, r_total == '0 && r_consumed == '0)
    `ASSERT_IMPLIES(a_head_live, i_clk, i_rst_n, r_count != '0, r_consumed < head_len)
    `ASSERT_NEXT(a_empty_take, i_clk, i_rst_n, i_step && i_item.kind == bbpq_pkg::KIND_TAKE && r_count == '0, r_count == '0 && $stable(r_head))

endmodule

// ===== rtl/core/branch_bit_packet_queue_core.sv =====
// Top level: branch-bit packet queue with input and result registers.
// Path: an item is held in the input reg, then the queue step fills the result reg.
// Throughput: one item per cycle while the result side does not stall; the queue
//   step is a single pass through the stop-bit priority encoder and the
//   head-entry bit select.
// Reset (i_rst_n low, synchronous): queue empty, pointers and bit total zero,
//   both pipeline registers empty. Entry storage is not cleared.
`timescale 1ns / 1ps
module branch_bit_packet_queue_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_kind,
    input  logic                                i_is_long,
    input  logic [bbpq_pkg::WORD_W-1:0]         i_packet,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2:0]                          o_outcome,
    output logic [bbpq_pkg::TOTAL_W-1:0]        o_pending_bits
);

    // Input stage holds one accepted item until the queue step runs.
    logic              r_in_valid;
    bbpq_pkg::t_item   r_in_item;
    // Result stage holds one result until the downstream transfer.
    logic              r_out_valid;
    bbpq_pkg::t_result r_out_result;

    logic              advance;   // result register can take a new value
    logic              step;      // queue processes the held item this cycle
    logic              in_xfer;
    bbpq_pkg::t_result step_result;

    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    bbpq_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item.kind    <= i_kind;
            r_in_item.is_long <= i_is_long;
            r_in_item.packet  <= i_packet;
        end
        if (step) begin
            r_out_result <= step_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_outcome      = r_out_result.outcome;
    assign o_pending_bits = r_out_result.pending_bits;

endmodule

// ===== tb/tb_branch_bit_packet_queue_core.sv =====
// Testbench for the branch-bit packet queue core: random and directed traffic, scoreboarded.
`timescale 1ns / 1ps
module tb_branch_bit_packet_queue_core;

    // Clock and reset; every input starts at a known value.
    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic                          i_kind         = bbpq_pkg::KIND_APPEND;
    logic                          i_is_long      = 1'b0;
    logic [bbpq_pkg::WORD_W-1:0]   i_packet       = '0;
    logic                          i_out_ready    = 1'b0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic [2:0]                    o_outcome;
    logic [bbpq_pkg::TOTAL_W-1:0]  o_pending_bits;

    always #5 i_clk = ~i_clk;

    branch_bit_packet_queue_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_is_long      (i_is_long),
        .i_packet       (i_packet),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_outcome      (o_outcome),
        .o_pending_bits (o_pending_bits)
    );

    // Items waiting to be driven, and results the queue model says must come back.
    bbpq_pkg::t_item   stim_q[$];
    bbpq_pkg::t_result result_q[$];
    int                fail_count = 0;

    // Shadow of the packet queue: stored words, payload lengths and long flags,
    // plus the ring pointers and the running bit total.
    logic [bbpq_pkg::WORD_W-1:0] shadow_word [bbpq_pkg::QUEUE_DEPTH];
    int                          shadow_len  [bbpq_pkg::QUEUE_DEPTH];
    logic                        shadow_long [bbpq_pkg::QUEUE_DEPTH];
    int                          shadow_head     = 0;
    int                          shadow_tail     = 0;
    int                          shadow_count    = 0;
    int                          shadow_consumed = 0;
    int                          shadow_total    = 0;

    // Advance the shadow queue by one item and return the result it must produce.
    function automatic bbpq_pkg::t_result queue_step(input bbpq_pkg::t_item it);
        bbpq_pkg::t_result r;
        int      offset;
        int      stop_pos;
        int      len;
        int      bit_pos;
        r.outcome = bbpq_pkg::OUT_EMPTY;
        if (it.kind == bbpq_pkg::KIND_APPEND) begin
            offset   = it.is_long ? int'(bbpq_pkg::LONG_OFFSET)
                                  : int'(bbpq_pkg::SHORT_OFFSET);
            stop_pos = -1;
            // Highest set bit is the stop bit; a zero word has none.
            for (int p = bbpq_pkg::WORD_W - 1; p >= 0; p--) begin
                if (it.packet[p] && stop_pos < 0) stop_pos = p;
            end
            if (stop_pos <= offset) begin
                r.outcome = bbpq_pkg::OUT_IGNORED;
            end else begin
                len = stop_pos - offset;
                if (shadow_count >= bbpq_pkg::QUEUE_DEPTH
                    || shadow_total + len > int'(bbpq_pkg::TOTAL_LIMIT)) begin
                    r.outcome = bbpq_pkg::OUT_DROPPED;
                end else begin
                    shadow_word[shadow_tail] = it.packet;
                    shadow_len[shadow_tail]  = len;
                    shadow_long[shadow_tail] = it.is_long;
                    shadow_tail   = (shadow_tail + 1) % bbpq_pkg::QUEUE_DEPTH;
                    shadow_count += 1;
                    shadow_total += len;
                    r.outcome = bbpq_pkg::OUT_APPENDED;
                end
            end
        end else if (shadow_count != 0) begin
            // MSB of the payload (just under the stop bit) goes out first.
            offset  = shadow_long[shadow_head] ? int'(bbpq_pkg::LONG_OFFSET)
                                               : int'(bbpq_pkg::SHORT_OFFSET);
            len     = shadow_len[shadow_head];
            bit_pos = (len + offset - 1 - shadow_consumed) & 63;
            r.outcome = shadow_word[shadow_head][bit_pos] ? bbpq_pkg::OUT_TAKEN
                                                          : bbpq_pkg::OUT_NOT_TAKEN;
            if (shadow_total > 0) shadow_total -= 1;
            shadow_consumed += 1;
            if (shadow_consumed >= len) begin
                shadow_consumed = 0;
                shadow_head     = (shadow_head + 1) % bbpq_pkg::QUEUE_DEPTH;
                shadow_count   -= 1;
            end
        end
        r.pending_bits = shadow_total[bbpq_pkg::TOTAL_W-1:0];
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long; zero in a burst stretch.
    function automatic int pick_gap(input bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Packet with a stop bit right above a payload of the given length, random below.
    function automatic logic [bbpq_pkg::WORD_W-1:0] framed_packet(input bit is_long,
                                                                  input int len);
        int                          stop_pos;
        logic [bbpq_pkg::WORD_W-1:0] below;
        stop_pos = (is_long ? int'(bbpq_pkg::LONG_OFFSET)
                            : int'(bbpq_pkg::SHORT_OFFSET)) + len;
        below    = ((64'd1 << stop_pos) - 64'd1) & {$urandom, $urandom};
        return below | (64'd1 << stop_pos);
    endfunction

    // Payload length: mostly short so the queue both fills and drains.
    function automatic int pick_len(input bit is_long);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 4);
        if (r < 95) return $urandom_range(5, 16);
        return $urandom_range(17, is_long ? 47 : 62);
    endfunction

    task automatic add_append(input bit is_long, input logic [bbpq_pkg::WORD_W-1:0] word);
        bbpq_pkg::t_item it;
        it.kind    = bbpq_pkg::KIND_APPEND;
        it.is_long = is_long;
        it.packet  = word;
        stim_q.push_back(it);
    endtask

    task automatic add_take();
        bbpq_pkg::t_item it;
        // Flag and word are don't-care on a take; randomize them anyway.
        it.kind    = bbpq_pkg::KIND_TAKE;
        it.is_long = 1'($urandom_range(0, 1));
        it.packet  = {$urandom, $urandom};
        stim_q.push_back(it);
    endtask

    // Input driver: holds each item until its transfer, then idles for a random gap.
    bbpq_pkg::t_item cur_item;
    bit              in_flight = 1'b0;
    int              in_gap    = 0;
    bit              in_burst  = 1'b0;

    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_flight   = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) result_q.push_back(queue_step(cur_item));
            if (i_in_valid && !o_in_ready) begin
                // stalled: keep valid and payload as they are
            end else if (in_gap > 0) begin
                in_gap     -= 1;
                i_in_valid <= 1'b0;
                in_flight   = 1'b0;
            end else if (stim_q.size() != 0) begin
                cur_item    = stim_q.pop_front();
                i_in_valid <= 1'b1;
                i_kind     <= cur_item.kind;
                i_is_long  <= cur_item.is_long;
                i_packet   <= cur_item.packet;
                in_flight   = 1'b1;
                in_gap      = pick_gap(in_burst);
                if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
            end else begin
                i_in_valid <= 1'b0;
                in_flight   = 1'b0;
            end
        end
    end

    // Result-side backpressure: random stalls with occasional stall-free stretches.
    int out_stall = 0;
    bit out_burst = 1'b0;

    always @(posedge i_clk) begin : sink
        if (out_stall > 0) begin
            out_stall   -= 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            out_stall    = pick_gap(out_burst);
            if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        end
    end

    // Monitor: each result transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin : monitor
        bbpq_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                if (fail_count < 10)
                    $display("[%0t] unexpected result: outcome=%0d pending=%0d",
                             $realtime, o_outcome, o_pending_bits);
                fail_count += 1;
            end else begin
                want = result_q.pop_front();
                if (o_outcome !== want.outcome || o_pending_bits !== want.pending_bits) begin
                    if (fail_count < 10)
                        $display("[%0t] mismatch: outcome exp=%0d got=%0d, pending exp=%0d got=%0d",
                                 $realtime, want.outcome, o_outcome,
                                 want.pending_bits, o_pending_bits);
                    fail_count += 1;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int counted;
        int block_len;
        int take_pct;
        bit is_long;

        // Directed: take on empty queue.
        add_take();
        // Packets with no payload: zero word, stop bit at or below the offset.
        add_append(1'b0, 64'd0);
        add_append(1'b1, 64'd0);
        add_append(1'b0, 64'd1);
        add_append(1'b0, 64'd3);
        add_append(1'b1, 64'h1_FFFF);
        add_append(1'b1, 64'h8000);
        // Widest payloads of each form, the one-bit payloads, a short packet
        // whose stop bit sits above bit 7, then fill to the last slot.
        add_append(1'b0, '1);
        add_append(1'b1, '1);
        add_append(1'b0, 64'h4);
        add_append(1'b1, 64'h2_A5A5);
        add_append(1'b0, 64'h1A5);
        for (int k = 0; k < bbpq_pkg::QUEUE_DEPTH - 5; k++) begin
            is_long = k[0];
            add_append(is_long, framed_packet(is_long, $urandom_range(1, 8)));
        end
        // Queue full: this one is dropped.
        add_append(1'b0, framed_packet(1'b0, 3));
        add_take();
        add_take();
        add_take();

        // Random: phases that fill, drain, or mix, with a little no-payload noise.
        counted = 0;
        while (counted < 1300) begin
            case ($urandom_range(0, 2))
                0: begin block_len = $urandom_range(20, 40);  take_pct = 10; end
                1: begin block_len = $urandom_range(60, 120); take_pct = 95; end
                default: begin block_len = $urandom_range(30, 80); take_pct = 50; end
            endcase
            for (int k = 0; k < block_len; k++) begin
                is_long = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < take_pct) begin
                    add_take();
                    counted += 1;
                end else if ($urandom_range(0, 99) < 8) begin
                    if ($urandom_range(0, 1) == 0)
                        add_append(is_long, 64'd0);
                    else
                        add_append(is_long, is_long ? (64'h1_FFFF & {32'd0, $urandom})
                                                    : 64'($urandom_range(0, 3)));
                end else begin
                    add_append(is_long, framed_packet(is_long, pick_len(is_long)));
                    counted += 1;
                end
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || in_flight) @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        // Keep the monitor running to catch any stray result.
        repeat (10) @(posedge i_clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
